// ----- rtl/core/scda_pkg.sv -----
// Shared types, opcode codes and decode functions for the CDB analyzer.
// No dependencies; used by scda_decode and scsi_cdb_analyzer.
package scda_pkg;

    localparam int CountW  = 32;
    localparam int FactorW = 17;
    localparam int LenW    = 48;
    localparam int ProdW   = CountW + FactorW;

    localparam logic [LenW-1:0]    LEN_MAX       = {LenW{1'b1}};
    // 2352 data bytes plus 96 subchannel bytes per CD sector
    localparam logic [FactorW-1:0] CD_SECTOR_BYTES = FactorW'(2352 + 96);

    localparam logic [7:0] OP_READ6     = 8'h08;
    localparam logic [7:0] OP_READ10    = 8'h28;
    localparam logic [7:0] OP_READ12    = 8'ha8;
    localparam logic [7:0] OP_WRITE6    = 8'h0a;
    localparam logic [7:0] OP_WRITE10   = 8'h2a;
    localparam logic [7:0] OP_WRITE12   = 8'haa;
    localparam logic [7:0] OP_READ_CD   = 8'hbe;
    localparam logic [7:0] OP_READ_CD_MSF = 8'hb9;
    localparam logic [7:0] OP_VERIFY    = 8'h2f;

    localparam logic [7:0] OP_REZERO            = 8'h01;
    localparam logic [7:0] OP_REQUEST_SENSE     = 8'h03;
    localparam logic [7:0] OP_READ_BLOCK_LIMITS = 8'h05;
    localparam logic [7:0] OP_INQUIRY           = 8'h12;
    localparam logic [7:0] OP_MODE_SELECT6      = 8'h15;
    localparam logic [7:0] OP_MODE_SENSE6       = 8'h1a;
    localparam logic [7:0] OP_READ_CAPACITY     = 8'h25;
    localparam logic [7:0] OP_PREFETCH          = 8'h34;
    localparam logic [7:0] OP_READ_DEFECT       = 8'h37;
    localparam logic [7:0] OP_READ_SUBCHANNEL   = 8'h42;
    localparam logic [7:0] OP_READ_TOC          = 8'h43;
    localparam logic [7:0] OP_READ_DISC_INFO    = 8'h51;
    localparam logic [7:0] OP_READ_TRACK_INFO   = 8'h52;
    localparam logic [7:0] OP_MODE_SELECT10     = 8'h55;
    localparam logic [7:0] OP_MODE_SENSE10      = 8'h5a;
    localparam logic [7:0] OP_MECH_STATUS       = 8'hbd;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_OUT  = 2'd1;
    localparam logic [1:0] DIR_IN   = 2'd2;

    localparam int BYTCHK_BIT = 1;

    typedef struct packed {
        logic [4:0]         cdb_length;
        logic [1:0]         direction;
        logic               tlen_valid;
        logic               tlen_use;
        logic               need_use;
        logic               cd_sector;
        logic [CountW-1:0]  count;
    } t_dec;

    typedef struct packed {
        logic [4:0] cdb_length;
        logic [1:0] direction;
        logic       tlen_valid;
        logic       tlen_use;
        logic       need_use;
    } t_ctl;

    function automatic logic [4:0] group_length(input logic [2:0] grp);
        logic [4:0] len;
        case (grp)
            3'd0:    len = 5'd6;
            3'd1:    len = 5'd10;
            3'd2:    len = 5'd10;
            3'd3:    len = 5'd12;
            3'd4:    len = 5'd16;
            3'd5:    len = 5'd12;
            3'd6:    len = 5'd10;
            default: len = 5'd10;
        endcase
        return len;
    endfunction

    function automatic logic [1:0] list_direction(input logic [7:0] op);
        logic [1:0] dir;
        dir = DIR_NONE;
        if (op inside {OP_WRITE6, OP_WRITE10, OP_WRITE12, OP_MODE_SELECT6,
                       OP_MODE_SELECT10}) begin
            dir = DIR_OUT;
        end else if (op inside {OP_REZERO, OP_REQUEST_SENSE, OP_READ_BLOCK_LIMITS, OP_READ6,
                                OP_INQUIRY, OP_MODE_SENSE6, OP_MODE_SENSE10,
                                OP_READ_CAPACITY, OP_READ10, OP_PREFETCH, OP_READ_DEFECT,
                                OP_READ_SUBCHANNEL, OP_READ_TOC, OP_READ12,
                                OP_READ_DISC_INFO, OP_READ_TRACK_INFO,
                                OP_MECH_STATUS}) begin
            dir = DIR_IN;
        end
        return dir;
    endfunction

endpackage

// ----- rtl/core/scda_decode.sv -----
// Opcode decode for the CDB analyzer: length, direction, count selection.
// Depends on scda_pkg.
module scda_decode (
    input  logic [7:0]     i_opcode,
    input  logic [7:0]     i_cdb_byte1,
    input  logic [7:0]     i_cdb_byte4,
    input  logic [7:0]     i_cdb_byte6,
    input  logic [7:0]     i_cdb_byte7,
    input  logic [7:0]     i_cdb_byte8,
    input  logic [7:0]     i_cdb_byte9,
    output scda_pkg::t_dec o_dec
);

    logic [scda_pkg::CountW-1:0] w_cnt6;
    logic [scda_pkg::CountW-1:0] w_cnt10;
    logic [scda_pkg::CountW-1:0] w_cnt12;
    logic [scda_pkg::CountW-1:0] w_cnt_cd;

    assign w_cnt6   = {24'd0, i_cdb_byte4};
    assign w_cnt10  = {16'd0, i_cdb_byte7, i_cdb_byte8};
    assign w_cnt12  = {i_cdb_byte6, i_cdb_byte7, i_cdb_byte8, i_cdb_byte9};
    assign w_cnt_cd = {8'd0, i_cdb_byte6, i_cdb_byte7, i_cdb_byte8};

    always_comb begin
        o_dec            = '0;
        o_dec.cdb_length = scda_pkg::group_length(i_opcode[7:5]);
        o_dec.direction  = scda_pkg::list_direction(i_opcode);
        case (i_opcode)
            scda_pkg::OP_READ6: begin
                o_dec.need_use = 1'b1;
                o_dec.count    = w_cnt6;
            end
            scda_pkg::OP_READ10: begin
                o_dec.need_use = 1'b1;
                o_dec.count    = w_cnt10;
            end
            scda_pkg::OP_READ12: begin
                o_dec.need_use = 1'b1;
                o_dec.count    = w_cnt12;
            end
            scda_pkg::OP_WRITE6: begin
                o_dec.tlen_valid = 1'b1;
                o_dec.tlen_use   = 1'b1;
                o_dec.need_use   = 1'b1;
                o_dec.count      = w_cnt6;
            end
            scda_pkg::OP_WRITE10: begin
                o_dec.tlen_valid = 1'b1;
                o_dec.tlen_use   = 1'b1;
                o_dec.need_use   = 1'b1;
                o_dec.count      = w_cnt10;
            end
            scda_pkg::OP_WRITE12: begin
                o_dec.tlen_valid = 1'b1;
                o_dec.tlen_use   = 1'b1;
                o_dec.need_use   = 1'b1;
                o_dec.count      = w_cnt12;
            end
            scda_pkg::OP_READ_CD, scda_pkg::OP_READ_CD_MSF: begin
                o_dec.need_use  = 1'b1;
                o_dec.cd_sector = 1'b1;
                o_dec.count     = w_cnt_cd;
            end
            scda_pkg::OP_VERIFY: begin
                // without byte check the data length is cleared
                o_dec.tlen_valid = 1'b1;
                if (i_cdb_byte1[scda_pkg::BYTCHK_BIT]) begin
                    o_dec.direction = scda_pkg::DIR_OUT;
                    o_dec.tlen_use  = 1'b1;
                    o_dec.need_use  = 1'b1;
                    o_dec.count     = w_cnt10;
                end else begin
                    o_dec.direction = scda_pkg::DIR_NONE;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/core/scsi_cdb_analyzer.sv -----
// SCSI CDB analyzer: takes one command descriptor per cycle and returns its
// length, data direction, write-side transfer length and buffer requirement.
// Depends on scda_pkg and scda_decode.
//
// Each command passes through three register stages (decode, multiply,
// saturate/output); the first stage captures at the edge of the transfer and
// the result then moves through the multiply and output registers. One command
// is taken every cycle while the output is not stalled. The 32 x 17
// bit count-times-block-size multiplier in the middle stage sets the
// stage depth. A stall on the output fills empty stages first
// and holds the input only once all three are occupied. block_size is written
// over the APB port at byte address 0 and should change only while the block
// is idle; products above 2^48-1 saturate.
module scsi_cdb_analyzer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_opcode,
    input  logic [7:0]  i_cdb_byte1,
    input  logic [7:0]  i_cdb_byte4,
    input  logic [7:0]  i_cdb_byte6,
    input  logic [7:0]  i_cdb_byte7,
    input  logic [7:0]  i_cdb_byte8,
    input  logic [7:0]  i_cdb_byte9,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_cdb_length,
    output logic [1:0]  o_direction,
    output logic        o_transfer_len_valid,
    output logic [47:0] o_transfer_len,
    output logic [47:0] o_buffer_need
);

    localparam logic REG_BLOCK_SIZE = 1'b0;

    logic [scda_pkg::FactorW-1:0] r_block_size;

    scda_pkg::t_dec               w_dec;
    logic                         r_v1;
    scda_pkg::t_dec               r_d1;
    logic                         r_v2;
    scda_pkg::t_ctl               r_c2;
    logic [scda_pkg::ProdW-1:0]   r_p2;
    logic                         r_v3;

    logic                         w_rdy1;
    logic                         w_rdy2;
    logic                         w_rdy3;
    logic [scda_pkg::FactorW-1:0] w_factor;
    logic [scda_pkg::ProdW-1:0]   n_p2;
    logic [scda_pkg::LenW-1:0]    w_sat;

    // configuration port
    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_BLOCK_SIZE) begin
            prdata = {15'd0, r_block_size};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= scda_pkg::FactorW'(512);
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BLOCK_SIZE) begin
            r_block_size <= pwdata[scda_pkg::FactorW-1:0];
        end
    end

    // per-stage flow control: a stage advances when it is empty or drains
    assign w_rdy3     = !r_v3 || !i_out_stall;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_stall = !w_rdy1;

    scda_decode u_decode (
        .i_opcode    (i_opcode),
        .i_cdb_byte1 (i_cdb_byte1),
        .i_cdb_byte4 (i_cdb_byte4),
        .i_cdb_byte6 (i_cdb_byte6),
        .i_cdb_byte7 (i_cdb_byte7),
        .i_cdb_byte8 (i_cdb_byte8),
        .i_cdb_byte9 (i_cdb_byte9),
        .o_dec       (w_dec)
    );

    // stage 1: decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_d1 <= w_dec;
        end
    end

    // stage 2: multiply
    assign w_factor = r_d1.cd_sector ? scda_pkg::CD_SECTOR_BYTES : r_block_size;
    assign n_p2     = scda_pkg::ProdW'(r_d1.count) * scda_pkg::ProdW'(w_factor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_p2            <= n_p2;
            r_c2.cdb_length <= r_d1.cdb_length;
            r_c2.direction  <= r_d1.direction;
            r_c2.tlen_valid <= r_d1.tlen_valid;
            r_c2.tlen_use   <= r_d1.tlen_use;
            r_c2.need_use   <= r_d1.need_use;
        end
    end

    // stage 3: saturate and hold the result
    assign w_sat = r_p2[scda_pkg::ProdW-1] ? scda_pkg::LEN_MAX : r_p2[scda_pkg::LenW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            o_cdb_length         <= r_c2.cdb_length;
            o_direction          <= r_c2.direction;
            o_transfer_len_valid <= r_c2.tlen_valid;
            o_transfer_len       <= r_c2.tlen_use ? w_sat : '0;
            o_buffer_need        <= r_c2.need_use ? w_sat : '0;
        end
    end

    assign o_out_valid = r_v3;

endmodule

// ----- dv/scsi_cdb_analyzer_tb.sv -----
// Self-checking testbench for scsi_cdb_analyzer: directed CDB table, then random commands
// over several block sizes, with random idling on both sides of the stream.
// Depends on scda_pkg and the scsi_cdb_analyzer RTL.
module scsi_cdb_analyzer_tb;

    localparam logic [2:0] ADDR_BLOCK_SIZE = 3'd0;
    localparam logic [2:0] ADDR_SPARE      = 3'd4;

    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 330;
    localparam int NUM_VECTORS = 22;
    localparam int NUM_HOT     = 26;

    localparam logic [47:0] LEN_MAX         = scda_pkg::LEN_MAX;
    localparam logic [16:0] CD_SECTOR_BYTES = scda_pkg::CD_SECTOR_BYTES;
    localparam int          BYTCHK_BIT      = scda_pkg::BYTCHK_BIT;
    localparam logic [1:0]  DIR_NONE        = scda_pkg::DIR_NONE;
    localparam logic [1:0]  DIR_OUT         = scda_pkg::DIR_OUT;
    localparam logic [1:0]  DIR_IN          = scda_pkg::DIR_IN;

    localparam logic [7:0] OP_READ6             = scda_pkg::OP_READ6;
    localparam logic [7:0] OP_READ10            = scda_pkg::OP_READ10;
    localparam logic [7:0] OP_READ12            = scda_pkg::OP_READ12;
    localparam logic [7:0] OP_WRITE6            = scda_pkg::OP_WRITE6;
    localparam logic [7:0] OP_WRITE10           = scda_pkg::OP_WRITE10;
    localparam logic [7:0] OP_WRITE12           = scda_pkg::OP_WRITE12;
    localparam logic [7:0] OP_READ_CD           = scda_pkg::OP_READ_CD;
    localparam logic [7:0] OP_READ_CD_MSF       = scda_pkg::OP_READ_CD_MSF;
    localparam logic [7:0] OP_VERIFY            = scda_pkg::OP_VERIFY;
    localparam logic [7:0] OP_REZERO            = scda_pkg::OP_REZERO;
    localparam logic [7:0] OP_REQUEST_SENSE     = scda_pkg::OP_REQUEST_SENSE;
    localparam logic [7:0] OP_READ_BLOCK_LIMITS = scda_pkg::OP_READ_BLOCK_LIMITS;
    localparam logic [7:0] OP_INQUIRY           = scda_pkg::OP_INQUIRY;
    localparam logic [7:0] OP_MODE_SELECT6      = scda_pkg::OP_MODE_SELECT6;
    localparam logic [7:0] OP_MODE_SENSE6       = scda_pkg::OP_MODE_SENSE6;
    localparam logic [7:0] OP_READ_CAPACITY     = scda_pkg::OP_READ_CAPACITY;
    localparam logic [7:0] OP_PREFETCH          = scda_pkg::OP_PREFETCH;
    localparam logic [7:0] OP_READ_DEFECT       = scda_pkg::OP_READ_DEFECT;
    localparam logic [7:0] OP_READ_SUBCHANNEL   = scda_pkg::OP_READ_SUBCHANNEL;
    localparam logic [7:0] OP_READ_TOC          = scda_pkg::OP_READ_TOC;
    localparam logic [7:0] OP_READ_DISC_INFO    = scda_pkg::OP_READ_DISC_INFO;
    localparam logic [7:0] OP_READ_TRACK_INFO   = scda_pkg::OP_READ_TRACK_INFO;
    localparam logic [7:0] OP_MODE_SELECT10     = scda_pkg::OP_MODE_SELECT10;
    localparam logic [7:0] OP_MODE_SENSE10      = scda_pkg::OP_MODE_SENSE10;
    localparam logic [7:0] OP_MECH_STATUS       = scda_pkg::OP_MECH_STATUS;

    // opcodes outside the package set
    localparam logic [7:0] OP_TEST_UNIT_READY   = 8'h00;
    localparam logic [7:0] OP_VARIABLE_LEN      = 8'h7f;
    localparam logic [7:0] OP_SVC_ACTION_IN16   = 8'h9e;
    localparam logic [7:0] OP_VENDOR_C0         = 8'hc0;
    localparam logic [7:0] OP_VENDOR_FF         = 8'hff;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] byte1;
        logic [7:0] byte4;
        logic [7:0] byte6;
        logic [7:0] byte7;
        logic [7:0] byte8;
        logic [7:0] byte9;
    } t_cdb;

    typedef struct packed {
        logic [4:0]  cdb_length;
        logic [1:0]  direction;
        logic        tlen_valid;
        logic [47:0] transfer_len;
        logic [47:0] buffer_need;
    } t_decode;

    typedef struct packed {
        t_cdb    cdb;
        logic    known;
        t_decode result;
    } t_vector;

    localparam t_vector VECTORS [NUM_VECTORS] = '{
        '{'{OP_READ6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{5'd6, DIR_IN, 1'b0, 48'd0, 48'd0}},
        '{'{OP_READ6, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{5'd6, DIR_IN, 1'b0, 48'd0, 48'd130560}},
        '{'{OP_READ10, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'h00}, 1'b1,
          '{5'd10, DIR_IN, 1'b0, 48'd0, 48'd33553920}},
        '{'{OP_READ12, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
          '{5'd12, DIR_IN, 1'b0, 48'd0, 48'h01ff_ffff_fe00}},
        '{'{OP_WRITE6, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{5'd6, DIR_OUT, 1'b1, 48'd512, 48'd512}},
        '{'{OP_WRITE6, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
          '{5'd6, DIR_OUT, 1'b1, 48'd0, 48'd0}},
        '{'{OP_WRITE10, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34, 8'h00}, 1'b0, '0},
        '{'{OP_WRITE12, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
          '{5'd12, DIR_OUT, 1'b1, 48'h01ff_ffff_fe00, 48'h01ff_ffff_fe00}},
        '{'{OP_READ12, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h01}, 1'b0, '0},
        '{'{OP_READ_CD, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
        '{'{OP_READ_CD_MSF, 8'h00, 8'h00, 8'h01, 8'h23, 8'h45, 8'h00}, 1'b0, '0},
        '{'{OP_VERIFY, 8'h02, 8'h00, 8'h00, 8'hff, 8'hff, 8'h00}, 1'b0, '0},
        '{'{OP_VERIFY, 8'hfd, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
          '{5'd10, DIR_NONE, 1'b1, 48'd0, 48'd0}},
        '{'{OP_TEST_UNIT_READY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{5'd6, DIR_NONE, 1'b0, 48'd0, 48'd0}},
        '{'{OP_VENDOR_FF, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
          '{5'd10, DIR_NONE, 1'b0, 48'd0, 48'd0}},
        '{'{OP_MODE_SELECT6, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{5'd6, DIR_OUT, 1'b0, 48'd0, 48'd0}},
        '{'{OP_MODE_SELECT10, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00}, 1'b1,
          '{5'd10, DIR_OUT, 1'b0, 48'd0, 48'd0}},
        '{'{OP_INQUIRY, 8'h00, 8'h24, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{5'd6, DIR_IN, 1'b0, 48'd0, 48'd0}},
        '{'{OP_MECH_STATUS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00}, 1'b1,
          '{5'd12, DIR_IN, 1'b0, 48'd0, 48'd0}},
        '{'{OP_SVC_ACTION_IN16, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20}, 1'b1,
          '{5'd16, DIR_NONE, 1'b0, 48'd0, 48'd0}},
        '{'{OP_VARIABLE_LEN, 8'h00, 8'h00, 8'h00, 8'h18, 8'h00, 8'h00}, 1'b1,
          '{5'd12, DIR_NONE, 1'b0, 48'd0, 48'd0}},
        '{'{OP_VENDOR_C0, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa}, 1'b1,
          '{5'd10, DIR_NONE, 1'b0, 48'd0, 48'd0}}
    };

    // opcodes the random part favors: every listed and every counted command
    localparam logic [7:0] HOT_OPS [NUM_HOT] = '{
        OP_READ6, OP_READ10, OP_READ12, OP_WRITE6, OP_WRITE10, OP_WRITE12,
        OP_READ_CD, OP_READ_CD_MSF, OP_VERIFY, OP_VERIFY, OP_MODE_SELECT6,
        OP_MODE_SELECT10, OP_REZERO, OP_REQUEST_SENSE, OP_READ_BLOCK_LIMITS,
        OP_INQUIRY, OP_MODE_SENSE6, OP_MODE_SENSE10, OP_READ_CAPACITY, OP_PREFETCH,
        OP_READ_DEFECT, OP_READ_SUBCHANNEL, OP_READ_TOC, OP_READ_DISC_INFO,
        OP_READ_TRACK_INFO, OP_MECH_STATUS
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_opcode;
    logic [7:0]  i_cdb_byte1;
    logic [7:0]  i_cdb_byte4;
    logic [7:0]  i_cdb_byte6;
    logic [7:0]  i_cdb_byte7;
    logic [7:0]  i_cdb_byte8;
    logic [7:0]  i_cdb_byte9;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [4:0]  o_cdb_length;
    logic [1:0]  o_direction;
    logic        o_transfer_len_valid;
    logic [47:0] o_transfer_len;
    logic [47:0] o_buffer_need;

    t_decode     pending_decodes [$];
    t_decode     staged_decode;
    logic [16:0] block_size_shadow;
    int          send_idle_pct;
    int          stall_pct;
    int          mismatches;
    int          cycles;
    int          commands_sent;
    int          results_seen;
    int          saturated;

    scsi_cdb_analyzer dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_opcode            (i_opcode),
        .i_cdb_byte1         (i_cdb_byte1),
        .i_cdb_byte4         (i_cdb_byte4),
        .i_cdb_byte6         (i_cdb_byte6),
        .i_cdb_byte7         (i_cdb_byte7),
        .i_cdb_byte8         (i_cdb_byte8),
        .i_cdb_byte9         (i_cdb_byte9),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_cdb_length        (o_cdb_length),
        .o_direction         (o_direction),
        .o_transfer_len_valid(o_transfer_len_valid),
        .o_transfer_len      (o_transfer_len),
        .o_buffer_need       (o_buffer_need)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [47:0] bytes_for_blocks(input logic [31:0] count,
                                                     input logic [16:0] bsize);
        logic [48:0] prod;
        prod = 49'(count) * 49'(bsize);
        return (prod > 49'(LEN_MAX)) ? LEN_MAX : prod[47:0];
    endfunction

    function automatic logic [4:0] length_for_group(input logic [2:0] grp);
        case (grp)
            3'd0:       return 5'd6;
            3'd3, 3'd5: return 5'd12;
            3'd4:       return 5'd16;
            default:    return 5'd10;
        endcase
    endfunction

    function automatic logic [1:0] direction_for(input logic [7:0] op);
        case (op)
            OP_WRITE6, OP_WRITE10, OP_WRITE12, OP_MODE_SELECT6, OP_MODE_SELECT10: begin
                return DIR_OUT;
            end
            OP_REZERO, OP_REQUEST_SENSE, OP_READ_BLOCK_LIMITS, OP_READ6, OP_INQUIRY,
            OP_MODE_SENSE6, OP_MODE_SENSE10, OP_READ_CAPACITY, OP_READ10, OP_PREFETCH,
            OP_READ_DEFECT, OP_READ_SUBCHANNEL, OP_READ_TOC, OP_READ12,
            OP_READ_DISC_INFO, OP_READ_TRACK_INFO, OP_MECH_STATUS: begin
                return DIR_IN;
            end
            default: return DIR_NONE;
        endcase
    endfunction

    function automatic t_decode decode_cdb(input t_cdb c, input logic [16:0] bsize);
        logic [31:0] count10;
        logic [31:0] count12;
        logic [47:0] sectors;
        t_decode     r;
        count10 = {16'd0, c.byte7, c.byte8};
        count12 = {c.byte6, c.byte7, c.byte8, c.byte9};
        sectors = {24'd0, c.byte6, c.byte7, c.byte8};
        r = '0;
        r.cdb_length = length_for_group(c.opcode[7:5]);
        r.direction = direction_for(c.opcode);
        case (c.opcode)
            OP_READ6:  r.buffer_need = bytes_for_blocks({24'd0, c.byte4}, bsize);
            OP_READ10: r.buffer_need = bytes_for_blocks(count10, bsize);
            OP_READ12: r.buffer_need = bytes_for_blocks(count12, bsize);
            OP_WRITE6, OP_WRITE10, OP_WRITE12: begin
                r.tlen_valid = 1'b1;
                if (c.opcode == OP_WRITE6) begin
                    r.transfer_len = bytes_for_blocks({24'd0, c.byte4}, bsize);
                end else if (c.opcode == OP_WRITE10) begin
                    r.transfer_len = bytes_for_blocks(count10, bsize);
                end else begin
                    r.transfer_len = bytes_for_blocks(count12, bsize);
                end
                r.buffer_need = r.transfer_len;
            end
            OP_READ_CD, OP_READ_CD_MSF: r.buffer_need = sectors * 48'(CD_SECTOR_BYTES);
            OP_VERIFY: begin
                // without byte check the old data length is cleared, not kept
                r.tlen_valid = 1'b1;
                if (c.byte1[BYTCHK_BIT]) begin
                    r.transfer_len = bytes_for_blocks(count10, bsize);
                    r.buffer_need = r.transfer_len;
                    r.direction = DIR_OUT;
                end else begin
                    r.direction = DIR_NONE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] count_byte();
        case ($urandom_range(6))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_cdb random_cdb();
        t_cdb c;
        if ($urandom_range(99) < 65) begin
            c.opcode = HOT_OPS[$urandom_range(NUM_HOT - 1)];
        end else begin
            c.opcode = 8'($urandom);
        end
        c.byte1 = 8'($urandom);
        c.byte4 = count_byte();
        c.byte6 = count_byte();
        c.byte7 = count_byte();
        c.byte8 = count_byte();
        c.byte9 = count_byte();
        return c;
    endfunction

    function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        end
    endfunction

    // one command transfer; the expectation is staged before valid rises
    task automatic send_cdb(input t_cdb c, input logic known, input t_decode result);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        staged_decode = known ? result : decode_cdb(c, block_size_shadow);
        i_in_valid <= 1'b1;
        {i_opcode, i_cdb_byte1, i_cdb_byte4, i_cdb_byte6, i_cdb_byte7, i_cdb_byte8,
         i_cdb_byte9} <= c;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending_decodes.size() == 0);
    endtask

    task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write block_size, poke the unmapped slot, then read block_size back
    task automatic set_block_size(input logic [16:0] bsize, input logic [14:0] junk);
        logic [31:0] rd;
        apb_xfer(1'b1, ADDR_BLOCK_SIZE, {junk, bsize}, rd);
        block_size_shadow = bsize;
        apb_xfer(1'b1, ADDR_SPARE, $urandom, rd);
        apb_xfer(1'b0, ADDR_BLOCK_SIZE, 32'd0, rd);
        if (rd !== {15'd0, block_size_shadow}) begin
            flag_mismatch("block_size readback", 64'(block_size_shadow), 64'(rd));
        end
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_decode e;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_decodes.size() == 0) begin
                    flag_mismatch("result with nothing pending", 64'd0,
                                  64'(o_buffer_need));
                end else begin
                    e = pending_decodes.pop_front();
                    if (o_cdb_length !== e.cdb_length)
                        flag_mismatch("cdb_length", 64'(e.cdb_length), 64'(o_cdb_length));
                    if (o_direction !== e.direction)
                        flag_mismatch("direction", 64'(e.direction), 64'(o_direction));
                    if (o_transfer_len_valid !== e.tlen_valid)
                        flag_mismatch("transfer_len_valid", 64'(e.tlen_valid),
                                      64'(o_transfer_len_valid));
                    if (o_transfer_len !== e.transfer_len)
                        flag_mismatch("transfer_len", 64'(e.transfer_len),
                                      64'(o_transfer_len));
                    if (o_buffer_need !== e.buffer_need)
                        flag_mismatch("buffer_need", 64'(e.buffer_need),
                                      64'(o_buffer_need));
                end
            end
            // record after the check, so a transfer never covers a result of the same edge
            if (i_in_valid && !o_in_stall) begin
                pending_decodes.push_back(staged_decode);
                commands_sent++;
                if (staged_decode.buffer_need == LEN_MAX) saturated++;
            end
        end
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [16:0] bsize;
        logic [14:0] junk;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_BLOCK_SIZE;
        pwdata = 32'd0;
        i_in_valid = 1'b0;
        {i_opcode, i_cdb_byte1, i_cdb_byte4, i_cdb_byte6, i_cdb_byte7, i_cdb_byte8,
         i_cdb_byte9} = '0;
        i_out_stall = 1'b0;
        block_size_shadow = 17'd512;
        send_idle_pct = 35;
        stall_pct = 35;
        mismatches = 0;
        cycles = 0;
        commands_sent = 0;
        results_seen = 0;
        saturated = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at the reset block size
        for (int v = 0; v < NUM_VECTORS; v++) begin
            send_cdb(VECTORS[v].cdb, VECTORS[v].known, VECTORS[v].result);
        end
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            junk = 15'd0;
            case (phase)
                0:       bsize = 17'd1;
                1:       bsize = 17'd65536;
                2:       bsize = 17'($urandom_range(65536, 2));
                3:       bsize = 17'd0;
                4:       bsize = 17'h1ffff;
                default: begin
                    bsize = 17'($urandom_range(65536, 1));
                    junk = 15'($urandom);
                end
            endcase
            set_block_size(bsize, junk);
            // one long stretch with neither side holding back
            send_idle_pct = (phase == 1) ? 0 : 35;
            stall_pct = (phase == 1) ? 0 : 35;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 2 && n == PHASE_ITEMS / 2) drain();
                send_cdb(random_cdb(), 1'b0, '0);
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("%0d commands over %0d block sizes, %0d results checked, %0d saturated",
                 commands_sent, NUM_PHASES + 1, results_seen, saturated);
        $display("%0d mismatches, %0d results still pending", mismatches,
                 pending_decodes.size());
        if (mismatches == 0 && pending_decodes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
